// File: rtl/core/rpse_pkg.sv
// Shared types and constants for the rotated point set extents unit.
package rpse_pkg;

    // Configuration register map
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN = 1'd1;

    // Control that travels alongside each point through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } rpse_ctl_t;

endpackage

// File: rtl/core/rpse_rotate.sv
// Rotation pipeline: split multiplies, product assembly, sums, rounding and saturation.
module rpse_rotate #(
    parameter int COORD_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  rpse_pkg::rpse_ctl_t           ctl_in,
    input  logic signed [COORD_BITS-1:0]  x_in,
    input  logic signed [COORD_BITS-1:0]  y_in,
    input  logic signed [rpse_pkg::CFG_DATA_W-1:0] cos_q,
    input  logic signed [rpse_pkg::CFG_DATA_W-1:0] sin_q,
    output rpse_pkg::rpse_ctl_t           ctl_out,
    output logic signed [COORD_BITS-1:0]  rx_out,
    output logic signed [COORD_BITS-1:0]  ry_out
);

    localparam int TW     = rpse_pkg::CFG_DATA_W;
    localparam int LB     = COORD_BITS / 2;
    localparam int HB     = COORD_BITS - LB;
    localparam int PLO_W  = LB + 1 + TW;
    localparam int PHI_W  = HB + TW;
    localparam int PROD_W = COORD_BITS + TW;
    localparam int SUM_W  = COORD_BITS + TW + 1;

    localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] HALF_M1 = HALF - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    function automatic logic [COORD_BITS-1:0] saturate(input logic signed [SUM_W-1:0] v);
        logic [COORD_BITS-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[COORD_BITS-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[COORD_BITS-1:0];
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    rpse_pkg::rpse_ctl_t mul_ctl_reg, prod_ctl_reg, sum_ctl_reg, rnd_ctl_reg;

    logic signed [PLO_W-1:0]  xc_lo_reg, ys_lo_reg, yc_lo_reg, xs_lo_reg;
    logic signed [PHI_W-1:0]  xc_hi_reg, ys_hi_reg, yc_hi_reg, xs_hi_reg;
    logic signed [PROD_W-1:0] xc_reg, ys_reg, yc_reg, xs_reg;
    logic signed [SUM_W-1:0]  rx_sum_reg, ry_sum_reg;
    logic signed [COORD_BITS-1:0] rx_reg, ry_reg;

    logic signed [SUM_W-1:0] rx_bias, ry_bias, rx_shift, ry_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_ctl_reg  <= '0;
            prod_ctl_reg <= '0;
            sum_ctl_reg  <= '0;
            rnd_ctl_reg  <= '0;
        end
        else if (advance)
        begin
            mul_ctl_reg  <= ctl_in;
            prod_ctl_reg <= mul_ctl_reg;
            sum_ctl_reg  <= prod_ctl_reg;
            rnd_ctl_reg  <= sum_ctl_reg;
        end
    end

    // Each coordinate is split into an unsigned low half and a signed high half,
    // so that every multiplier stays within 17 by 32 bits (COORD_BITS of 32).
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xc_lo_reg <= PLO_W'($signed({1'b0, x_in[LB-1:0]})) * PLO_W'(cos_q);
            xc_hi_reg <= PHI_W'($signed(x_in[COORD_BITS-1:LB])) * PHI_W'(cos_q);
            ys_lo_reg <= PLO_W'($signed({1'b0, y_in[LB-1:0]})) * PLO_W'(sin_q);
            ys_hi_reg <= PHI_W'($signed(y_in[COORD_BITS-1:LB])) * PHI_W'(sin_q);
            yc_lo_reg <= PLO_W'($signed({1'b0, y_in[LB-1:0]})) * PLO_W'(cos_q);
            yc_hi_reg <= PHI_W'($signed(y_in[COORD_BITS-1:LB])) * PHI_W'(cos_q);
            xs_lo_reg <= PLO_W'($signed({1'b0, x_in[LB-1:0]})) * PLO_W'(sin_q);
            xs_hi_reg <= PHI_W'($signed(x_in[COORD_BITS-1:LB])) * PHI_W'(sin_q);

            xc_reg <= (PROD_W'(xc_hi_reg) <<< LB) + PROD_W'(xc_lo_reg);
            ys_reg <= (PROD_W'(ys_hi_reg) <<< LB) + PROD_W'(ys_lo_reg);
            yc_reg <= (PROD_W'(yc_hi_reg) <<< LB) + PROD_W'(yc_lo_reg);
            xs_reg <= (PROD_W'(xs_hi_reg) <<< LB) + PROD_W'(xs_lo_reg);

            rx_sum_reg <= SUM_W'(xc_reg) - SUM_W'(ys_reg);
            ry_sum_reg <= SUM_W'(yc_reg) + SUM_W'(xs_reg);

            rx_reg <= saturate(rx_shift);
            ry_reg <= saturate(ry_shift);
        end
    end

    // Rounding half away from zero: a negative sum takes one less than half
    // before the arithmetic shift, which floors towards minus infinity.
    always_comb
    begin
        rx_bias  = rx_sum_reg + (rx_sum_reg[SUM_W-1] ? HALF_M1 : HALF);
        ry_bias  = ry_sum_reg + (ry_sum_reg[SUM_W-1] ? HALF_M1 : HALF);
        rx_shift = rx_bias >>> TRIG_FRAC_BITS;
        ry_shift = ry_bias >>> TRIG_FRAC_BITS;
    end

    assign ctl_out = rnd_ctl_reg;
    assign rx_out  = rx_reg;
    assign ry_out  = ry_reg;

endmodule

// File: rtl/core/rotated_point_set_extents_unit.sv
// Top level of the rotated point set extents unit: input stage, rotation, running box.
//
// Rotates each point by the angle whose cosine and sine sit in registers 0 and 1
// (signed fixed point with TRIG_FRAC_BITS fraction bits), rounds half away from
// zero, saturates, and keeps the running minimum and maximum of the rotated x and
// y; the point flagged last emits the box and starts a fresh list. One point is
// accepted every clock cycle unless an offered box is not taken, and the box of a
// list travels through an input register, four rotation stages (split multiplies,
// product assembly, sums, rounding) and the box register. The whole pipeline
// moves as one and holds only while an offered box is not taken. Write the trig
// registers only while no list is in flight.
module rotated_point_set_extents_unit #(
    parameter int COORD_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 30
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_write_en,
    input  logic [rpse_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rpse_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   point_valid,
    output logic                                   point_ready,
    input  logic signed [COORD_BITS-1:0]           point_x,
    input  logic signed [COORD_BITS-1:0]           point_y,
    input  logic                                   last_point,

    output logic                                   box_valid,
    input  logic                                   box_ready,
    output logic signed [COORD_BITS-1:0]           box_min_x,
    output logic signed [COORD_BITS-1:0]           box_min_y,
    output logic signed [COORD_BITS-1:0]           box_max_x,
    output logic signed [COORD_BITS-1:0]           box_max_y
);

    localparam int TW = rpse_pkg::CFG_DATA_W;
    localparam logic [TW-1:0] COS_RESET = TW'(1) << TRIG_FRAC_BITS;

    logic advance;

    logic signed [TW-1:0] cos_reg, sin_reg;

    rpse_pkg::rpse_ctl_t in_ctl_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;

    rpse_pkg::rpse_ctl_t rot_ctl;
    logic signed [COORD_BITS-1:0] rx, ry;

    logic have_point_reg;
    logic signed [COORD_BITS-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic signed [COORD_BITS-1:0] min_x_next, min_y_next, max_x_next, max_y_next;

    logic box_valid_reg;
    logic signed [COORD_BITS-1:0] box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;

    // The pipeline moves whenever the box register is empty or being drained.
    assign advance     = !box_valid_reg || box_ready;
    assign point_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= COS_RESET;
            sin_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rpse_pkg::CFG_COS: cos_reg <= cfg_data;
                rpse_pkg::CFG_SIN: sin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else if (advance)
        begin
            in_ctl_reg.valid <= point_valid;
            in_ctl_reg.last  <= last_point;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= point_x;
            y_reg <= point_y;
        end
    end

    rpse_rotate #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ctl_in  (in_ctl_reg),
        .x_in    (x_reg),
        .y_in    (y_reg),
        .cos_q   (cos_reg),
        .sin_q   (sin_reg),
        .ctl_out (rot_ctl),
        .rx_out  (rx),
        .ry_out  (ry)
    );

    // The first point of a list seeds all four extents.
    always_comb
    begin
        min_x_next = (!have_point_reg || (rx < min_x_reg)) ? rx : min_x_reg;
        min_y_next = (!have_point_reg || (ry < min_y_reg)) ? ry : min_y_reg;
        max_x_next = (!have_point_reg || (rx > max_x_reg)) ? rx : max_x_reg;
        max_y_next = (!have_point_reg || (ry > max_y_reg)) ? ry : max_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_point_reg <= 1'b0;
            box_valid_reg  <= 1'b0;
            min_x_reg      <= '0;
            min_y_reg      <= '0;
            max_x_reg      <= '0;
            max_y_reg      <= '0;
        end
        else if (advance)
        begin
            box_valid_reg <= rot_ctl.valid && rot_ctl.last;
            if (rot_ctl.valid)
            begin
                if (rot_ctl.last)
                begin
                    have_point_reg <= 1'b0;
                    min_x_reg      <= '0;
                    min_y_reg      <= '0;
                    max_x_reg      <= '0;
                    max_y_reg      <= '0;
                end
                else
                begin
                    have_point_reg <= 1'b1;
                    min_x_reg      <= min_x_next;
                    min_y_reg      <= min_y_next;
                    max_x_reg      <= max_x_next;
                    max_y_reg      <= max_y_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rot_ctl.valid && rot_ctl.last)
        begin
            box_min_x_reg <= min_x_next;
            box_min_y_reg <= min_y_next;
            box_max_x_reg <= max_x_next;
            box_max_y_reg <= max_y_next;
        end
    end

    assign box_valid = box_valid_reg;
    assign box_min_x = box_min_x_reg;
    assign box_min_y = box_min_y_reg;
    assign box_max_x = box_max_x_reg;
    assign box_max_y = box_max_y_reg;

endmodule

// File: rtl/core/rpse_checker.sv
// Port-level checks for the rotated point set extents unit, bound to the top level.
module rpse_checker #(
    parameter int COORD_BITS = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          point_ready,
    input logic                          box_valid,
    input logic                          box_ready,
    input logic signed [COORD_BITS-1:0]  box_min_x,
    input logic signed [COORD_BITS-1:0]  box_min_y,
    input logic signed [COORD_BITS-1:0]  box_max_x,
    input logic signed [COORD_BITS-1:0]  box_max_y
);

    // An offered box that is not taken stays offered.
    a_box_held: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_ready |=> box_valid)
        else $error("box withdrawn before its transfer");

    // A stalled box keeps its contents.
    a_box_stable: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_ready |=> $stable(box_min_x) && $stable(box_min_y)
                                     && $stable(box_max_x) && $stable(box_max_y))
        else $error("box changed while stalled");

    // A box never has its minimum above its maximum.
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
        else $error("box minimum exceeds maximum");

    // With no box waiting, points are always taken.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !box_valid |-> point_ready)
        else $error("point refused with an empty output register");

endmodule

bind rotated_point_set_extents_unit rpse_checker #(
    .COORD_BITS (COORD_BITS)
) u_rpse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_ready (point_ready),
    .box_valid   (box_valid),
    .box_ready   (box_ready),
    .box_min_x   (box_min_x),
    .box_min_y   (box_min_y),
    .box_max_x   (box_max_x),
    .box_max_y   (box_max_y)
);

// File: dv/testbench.sv
// Self-checking testbench for the rotated point set extents unit.
module testbench;

    localparam int COORD_W        = 32;
    localparam int FRAC_BITS      = 30;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [31:0] TRIG_ONE     = 32'h4000_0000;
    localparam logic [31:0] TRIG_MINUS_1 = 32'hC000_0000;
    localparam logic [31:0] TRIG_HALF    = 32'h2000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
    } box_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_write_en;
    logic [rpse_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [rpse_pkg::CFG_DATA_W-1:0]       cfg_data;
    logic                                  point_valid;
    logic                                  point_ready;
    logic signed [COORD_W-1:0]             point_x;
    logic signed [COORD_W-1:0]             point_y;
    logic                                  last_point;
    logic                                  box_valid;
    logic                                  box_ready;
    logic signed [COORD_W-1:0]             box_min_x;
    logic signed [COORD_W-1:0]             box_min_y;
    logic signed [COORD_W-1:0]             box_max_x;
    logic signed [COORD_W-1:0]             box_max_y;

    // Predictor state: the trig registers and the running box of the open list.
    logic signed [31:0]           model_cos;
    logic signed [31:0]           model_sin;
    logic                         list_open;
    box_t                         running_box;
    box_t                         expected_boxes[$];

    int  mismatch_count;
    int  points_sent;
    int  boxes_checked;
    int  angles_loaded;
    int  idle_cycles;
    bit  bursts_on;
    bit  hold_pending;

    rotated_point_set_extents_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_point   (last_point),
        .box_valid    (box_valid),
        .box_ready    (box_ready),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scale an exact sum down by the fraction bits, rounding half away from zero,
    // and clamp it to the coordinate range.
    function automatic logic signed [COORD_W-1:0] scale_round_sat(
        input logic signed [95:0] acc);
        logic        negative;
        logic [95:0] mag;
        logic [95:0] limit;
        negative = acc[95];
        mag      = negative ? -acc : acc;
        mag      = (mag + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        limit    = negative ? 96'h8000_0000 : 96'h7FFF_FFFF;
        if (mag > limit)
            mag = limit;
        return negative ? -mag[COORD_W-1:0] : mag[COORD_W-1:0];
    endfunction

    function automatic void predict_point(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic last);
        logic signed [95:0]        wx, wy, wc, ws;
        logic signed [COORD_W-1:0] rx, ry;
        wx = 96'(x);
        wy = 96'(y);
        wc = 96'(model_cos);
        ws = 96'(model_sin);
        rx = scale_round_sat(wx * wc - wy * ws);
        ry = scale_round_sat(wy * wc + wx * ws);
        if (!list_open)
        begin
            running_box.min_x = rx;
            running_box.max_x = rx;
            running_box.min_y = ry;
            running_box.max_y = ry;
        end
        else
        begin
            if (rx < running_box.min_x) running_box.min_x = rx;
            if (ry < running_box.min_y) running_box.min_y = ry;
            if (rx > running_box.max_x) running_box.max_x = rx;
            if (ry > running_box.max_y) running_box.max_y = ry;
        end
        if (last)
        begin
            expected_boxes = {expected_boxes, running_box};
            running_box = '0;
            list_open   = 1'b0;
        end
        else
        begin
            list_open = 1'b1;
        end
    endfunction

    function automatic void check_field(input string field,
                                        input logic signed [COORD_W-1:0] want,
                                        input logic signed [COORD_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("box %0d: %s expected %0d, got %0d",
                         boxes_checked, field, want, got);
        end
    endfunction

    // Result checker: every box transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        box_t want;
        if (rst_n && box_valid && box_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected box: min (%0d, %0d) max (%0d, %0d)",
                             box_min_x, box_min_y, box_max_x, box_max_y);
            end
            else
            begin
                want = expected_boxes.pop_front();
                check_field("box_min_x", want.min_x, box_min_x);
                check_field("box_min_y", want.min_y, box_min_y);
                check_field("box_max_x", want.max_x, box_max_x);
                check_field("box_max_y", want.max_y, box_max_y);
            end
            boxes_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (point_valid && point_ready) || (box_valid && box_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Box receiver: random stall bursts, plus one long hold when requested.
    initial
    begin
        box_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                box_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 3) == 0)
            begin
                box_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                box_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one point and hold it until the transfer; valid is left high so that
    // back-to-back points need no extra cycle.
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic last);
        point_valid <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        last_point  <= last;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        predict_point(x, y, last);
        points_sent++;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Stop offering points and let every outstanding box come out.
    task automatic drain_boxes();
        point_valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_angle(input logic [31:0] cos_val, input logic [31:0] sin_val);
        cfg_write_en <= 1'b1;
        cfg_index    <= rpse_pkg::CFG_COS;
        cfg_data     <= cos_val;
        @(posedge clk);
        cfg_index    <= rpse_pkg::CFG_SIN;
        cfg_data     <= sin_val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        model_cos = cos_val;
        model_sin = sin_val;
        angles_loaded++;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 6))
            0: return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
            1, 2: return $urandom;
            3: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom) >>> $urandom_range(1, 24);
        endcase
    endfunction

    function automatic logic [31:0] pick_trig();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? TRIG_ONE : TRIG_MINUS_1;
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    task automatic send_list(input int length);
        for (int i = 1; i <= length; i++)
            send_point(pick_coord(), pick_coord(), i == length);
    endtask

    task automatic run_single_point_lists();
        send_point(0, 0, 1'b1);
        send_point(-1, 1, 1'b1);
        drain_boxes();
    endtask

    task automatic run_extreme_coords();
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        drain_boxes();
        // A factor of one half in both trig registers puts odd x with zero y exactly on the rounding midpoint.
        load_angle(TRIG_HALF, TRIG_HALF);
        send_point(1, 0, 1'b0);
        send_point(-1, 0, 1'b0);
        send_point(3, 0, 1'b0);
        send_point(-3, 1, 1'b1);
        drain_boxes();
    endtask

    task automatic run_trig_extremes();
        logic [31:0] cos_set[5];
        logic [31:0] sin_set[5];
        cos_set = '{32'h0, TRIG_MINUS_1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
        sin_set = '{TRIG_ONE, 32'h0, TRIG_MINUS_1, 32'h7FFF_FFFF, 32'h8000_0000};
        for (int i = 0; i < 5; i++)
        begin
            load_angle(cos_set[i], sin_set[i]);
            send_point(COORD_MAX, COORD_MIN, 1'b0);
            send_point(COORD_MIN, COORD_MAX, 1'b0);
            send_point(12345, -678, 1'b1);
            drain_boxes();
        end
    endtask

    // Hold the box output for a long stretch while short lists keep coming,
    // so the pipeline fills and refuses further points.
    task automatic run_output_stall();
        load_angle(pick_trig(), pick_trig());
        hold_pending = 1'b1;
        for (int i = 0; i < 40; i++)
            send_list($urandom_range(1, 2));
        drain_boxes();
        while (hold_pending)
            @(posedge clk);
    endtask

    task automatic run_random_lists();
        int phase_points;
        for (int phase = 0; phase < 14; phase++)
        begin
            bursts_on = (phase < 11) && (phase % 3 != 2);
            load_angle(pick_trig(), pick_trig());
            phase_points = 0;
            while (phase_points < 125)
            begin
                int length;
                length = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                send_list(length);
                phase_points += length;
            end
            drain_boxes();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = rpse_pkg::CFG_COS;
        cfg_data       = '0;
        point_valid    = 1'b0;
        point_x        = '0;
        point_y        = '0;
        last_point     = 1'b0;
        model_cos      = TRIG_ONE;
        model_sin      = '0;
        list_open      = 1'b0;
        running_box    = '0;
        mismatch_count = 0;
        points_sent    = 0;
        boxes_checked  = 0;
        angles_loaded  = 0;
        idle_cycles    = 0;
        bursts_on      = 1'b1;
        hold_pending   = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_single_point_lists();
        run_extreme_coords();
        run_trig_extremes();
        run_output_stall();
        run_random_lists();

        $display("Sent %0d points under %0d trig settings; %0d boxes compared.",
                 points_sent, angles_loaded, boxes_checked);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
